[hw/rtl/pwm_duty_cycle_capture_defines.svh]
// Assertion helpers for the PWM duty-cycle capture block.
// Each macro checks on the rising edge of clk and is off while rst_n is low.
`ifndef PWM_DUTY_CYCLE_CAPTURE_DEFINES_SVH
`define PWM_DUTY_CYCLE_CAPTURE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PDCC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PDCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/pdcc_pkg.sv]
package pdcc_pkg;

  localparam int COUNT_WIDTH    = 24;
  localparam int DUTY_FRAC_BITS = 8;
  localparam int IVL_W          = 24;

  localparam int DUTY_W = 7 + DUTY_FRAC_BITS;
  localparam int PROD_W = COUNT_WIDTH + 7;
  localparam int NUM_W  = PROD_W + DUTY_FRAC_BITS;
  localparam int TOT_W  = COUNT_WIDTH + 1;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [IVL_W-1:0]       ivl_t;
  typedef logic [DUTY_W-1:0]      duty_t;
  typedef logic [PROD_W-1:0]      prod_t;
  typedef logic [NUM_W-1:0]       num_t;
  typedef logic [TOT_W-1:0]       tot_t;

  localparam count_t CNT_MAX      = '1;
  localparam ivl_t   IVL_MAX      = '1;
  localparam ivl_t   IVL_RESET    = IVL_W'(10000);
  localparam prod_t  DUTY_SCALE   = PROD_W'(100);
  localparam duty_t  DUTY_MAX     = DUTY_W'(100 << DUTY_FRAC_BITS);

  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_WAIT_HIGH = 2'd1;
  localparam logic [1:0] PH_HIGH      = 2'd2;
  localparam logic [1:0] PH_LOW       = 2'd3;

  function automatic count_t sat_inc(input count_t v);
    return (v == CNT_MAX) ? v : v + count_t'(1);
  endfunction

endpackage

[hw/rtl/pdcc_div.sv]
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// DUTY_W bits, which holds because the numerator is at most 100% of scale.
module pdcc_div
  import pdcc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  num_t  num,
  input  tot_t  den,
  output logic  busy,
  output logic  done,
  output duty_t quotient
);

  localparam int STEP_W = $clog2(DUTY_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  tot_t              rem_r, rem_nxt;
  tot_t              den_r, den_nxt;
  duty_t             bits_r, bits_nxt;
  duty_t             q_r, q_nxt;
  logic [TOT_W:0]    trial;
  logic [TOT_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, bits_r[DUTY_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    bits_nxt = bits_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(DUTY_W - 1);
      rem_nxt  = TOT_W'(num[NUM_W-1:DUTY_W]);
      bits_nxt = num[DUTY_W-1:0];
      den_nxt  = den;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
      q_nxt    = {q_r[DUTY_W-2:0], ge};
      bits_nxt = {bits_r[DUTY_W-2:0], 1'b0};
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    bits_r <= bits_nxt;
    q_r    <= q_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

[hw/rtl/pwm_duty_cycle_capture.sv]
// PWM duty-cycle capture.
// The input channel (in_valid / in_stall / in_pin_level) carries one PWM pin
// sample per transaction; every accepted transaction is one sample tick.
// An interval counter, restarted by each measurement start, sets how often a
// measurement begins; cfg_interval_ticks (cfg_valid / cfg_ready) sets that
// interval, and the user must write it only while the block is idle (the
// block itself does not enforce this). A zero interval acts like one.
// A measurement waits for a high sample, counts high then low samples, and
// ends on the first high sample after the low run. The result channel
// (out_valid / out_stall) then carries the high count, low count, the duty
// cycle in percent with eight fraction bits (floored) and a saturation flag.
// Samples are taken one per cycle except at a measurement's end: the duty
// division runs on a single one-bit-per-cycle divider, and the result passes
// the start register, the divider and its done register before it shows on
// out_valid. in_stall stays high from the edge that takes the ending sample
// until the divider is done, and the next sample can be taken at the edge
// that loads the result. While a result waits under out_stall, samples are
// still taken unless the block is in its low phase, where the next sample
// could end another measurement. Reset (rst_n low at a clock edge) restores
// the interval to 10000 ticks, clears all counters and drops out_valid.
module pwm_duty_cycle_capture
  import pdcc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_stall,
  input  logic   in_pin_level,
  output logic   out_valid,
  input  logic   out_stall,
  output count_t out_high_ticks,
  output count_t out_low_ticks,
  output duty_t  out_duty_percent_q8,
  output logic   out_saturated,
  input  logic   cfg_valid,
  output logic   cfg_ready,
  input  ivl_t   cfg_interval_ticks
);

  // Measurement state.
  logic [1:0] phase_r, phase_nxt;
  ivl_t       ivl_ticks_r, ivl_ticks_nxt;
  ivl_t       ivl_count_r, ivl_count_nxt;
  count_t     high_r, high_nxt;
  count_t     low_r, low_nxt;

  // Divider operands, registered after the multiply and the add.
  prod_t      prod_r, prod_nxt;
  tot_t       tot_r, tot_nxt;
  logic       start_r, start_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  count_t     out_high_r, out_high_nxt;
  count_t     out_low_r, out_low_nxt;
  duty_t      out_duty_r, out_duty_nxt;
  logic       out_sat_r, out_sat_nxt;

  logic       in_acc;
  logic [1:0] eff_phase;
  ivl_t       ivl_inc;
  logic       div_busy;
  logic       div_done;
  duty_t      div_q;

  // No sample may enter while the divider works, nor in the low phase while
  // the previous result is still held, since that sample might end a
  // measurement.
  assign in_stall  = start_r | div_busy | (out_valid_r & (phase_r == PH_LOW));
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign ivl_inc   = (ivl_count_r == IVL_MAX) ? ivl_count_r : ivl_count_r + ivl_t'(1);

  always_comb begin
    phase_nxt     = phase_r;
    ivl_ticks_nxt = ivl_ticks_r;
    ivl_count_nxt = ivl_count_r;
    high_nxt      = high_r;
    low_nxt       = low_r;
    prod_nxt      = prod_r;
    tot_nxt       = tot_r;
    start_nxt     = 1'b0;
    eff_phase     = phase_r;

    if (cfg_valid) begin
      ivl_ticks_nxt = cfg_interval_ticks;
    end

    if (in_acc) begin
      ivl_count_nxt = ivl_inc;
      // The sample that ends the idle interval is already a wait-high sample.
      if ((phase_r == PH_IDLE) && (ivl_inc >= ivl_ticks_r)) begin
        ivl_count_nxt = '0;
        eff_phase     = PH_WAIT_HIGH;
        phase_nxt     = PH_WAIT_HIGH;
      end
      case (eff_phase)
        PH_WAIT_HIGH: begin
          if (in_pin_level) begin
            high_nxt  = count_t'(1);
            phase_nxt = PH_HIGH;
          end
        end
        PH_HIGH: begin
          if (in_pin_level) begin
            high_nxt = sat_inc(high_r);
          end else begin
            low_nxt   = count_t'(1);
            phase_nxt = PH_LOW;
          end
        end
        PH_LOW: begin
          if (!in_pin_level) begin
            low_nxt = sat_inc(low_r);
          end else begin
            // End of measurement: scale the high count and form the period,
            // then hand both to the divider on the next cycle.
            prod_nxt  = PROD_W'(high_r) * DUTY_SCALE;
            tot_nxt   = TOT_W'(high_r) + TOT_W'(low_r);
            start_nxt = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  pdcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .num      (NUM_W'(prod_r) << DUTY_FRAC_BITS),
    .den      (tot_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // The counts stay put while the divider runs, so they are captured together
  // with the quotient.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_high_nxt  = out_high_r;
    out_low_nxt   = out_low_r;
    out_duty_nxt  = out_duty_r;
    out_sat_nxt   = out_sat_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (div_done) begin
      out_valid_nxt = 1'b1;
      out_high_nxt  = high_r;
      out_low_nxt   = low_r;
      out_duty_nxt  = div_q;
      out_sat_nxt   = (high_r == CNT_MAX) || (low_r == CNT_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      ivl_ticks_r <= IVL_RESET;
      ivl_count_r <= '0;
      high_r      <= '0;
      low_r       <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      ivl_ticks_r <= ivl_ticks_nxt;
      ivl_count_r <= ivl_count_nxt;
      high_r      <= high_nxt;
      low_r       <= low_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r     <= prod_nxt;
    tot_r      <= tot_nxt;
    out_high_r <= out_high_nxt;
    out_low_r  <= out_low_nxt;
    out_duty_r <= out_duty_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_high_ticks      = out_high_r;
  assign out_low_ticks       = out_low_r;
  assign out_duty_percent_q8 = out_duty_r;
  assign out_saturated       = out_sat_r;

endmodule

[hw/rtl/pdcc_chk.sv]
`include "pwm_duty_cycle_capture_defines.svh"

module pdcc_chk
  import pdcc_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_stall,
  input logic   out_valid,
  input logic   out_stall,
  input count_t out_high_ticks,
  input count_t out_low_ticks,
  input duty_t  out_duty_percent_q8
);

  // A held result keeps its duty value.
  `PDCC_ASSERT_NEXT(a_duty_held, out_valid && out_stall, $stable(out_duty_percent_q8), "duty changed while stalled")

  // A new result only appears after the input side was held off for the divide.
  `PDCC_ASSERT_SAME(a_div_stall, $rose(out_valid), $past(in_stall, 2), "result without divide stall")

  // Duty never exceeds one hundred percent.
  `PDCC_ASSERT_SAME(a_duty_max, out_valid, out_duty_percent_q8 <= DUTY_MAX, "duty above full scale")

  // Every measurement has at least one high and one low sample.
  `PDCC_ASSERT_SAME(a_counts_nz, out_valid, (out_high_ticks != '0) && (out_low_ticks != '0), "zero count in result")

endmodule

bind pwm_duty_cycle_capture pdcc_chk u_pdcc_chk (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_high_ticks      (out_high_ticks),
  .out_low_ticks       (out_low_ticks),
  .out_duty_percent_q8 (out_duty_percent_q8)
);

[sim/pwm_capture_checker.sv]
`timescale 1ns / 100ps

module pwm_capture_checker
  import pdcc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_stall,
  input  logic   in_pin_level,
  input  logic   out_valid,
  input  logic   out_stall,
  input  count_t out_high_ticks,
  input  count_t out_low_ticks,
  input  duty_t  out_duty_percent_q8,
  input  logic   out_saturated,
  input  logic   cfg_valid,
  input  logic   cfg_ready,
  input  ivl_t   cfg_interval_ticks,
  output int     mismatch_count,
  output int     readings_pending
);

  typedef struct packed {
    count_t high_ticks;
    count_t low_ticks;
    duty_t  duty;
    logic   saturated;
  } pwm_reading_t;

  pwm_reading_t expected_readings[$];

  logic [1:0] capture_phase;
  ivl_t       ticks_since_start;
  ivl_t       interval_setting;
  count_t     high_run;
  count_t     low_run;
  int         mismatches;

  // Advances the capture state by one pin sample and queues a reading when
  // the sample closes a measurement.
  task automatic take_sample(input logic level);
    logic [63:0]  total;
    logic [63:0]  quotient;
    pwm_reading_t reading;
    if (ticks_since_start != IVL_MAX) begin
      ticks_since_start = ticks_since_start + 1'b1;
    end
    if (capture_phase == PH_IDLE && ticks_since_start >= interval_setting) begin
      ticks_since_start = '0;
      capture_phase = PH_WAIT_HIGH;
    end
    case (capture_phase)
      PH_WAIT_HIGH: begin
        if (level) begin
          high_run = count_t'(1);
          capture_phase = PH_HIGH;
        end
      end
      PH_HIGH: begin
        if (!level) begin
          low_run = count_t'(1);
          capture_phase = PH_LOW;
        end else if (high_run != CNT_MAX) begin
          high_run = high_run + 1'b1;
        end
      end
      PH_LOW: begin
        if (!level) begin
          if (low_run != CNT_MAX) begin
            low_run = low_run + 1'b1;
          end
        end else begin
          total = 64'(high_run) + 64'(low_run);
          quotient = ((64'(high_run) * 64'd100) << DUTY_FRAC_BITS) / total;
          reading.high_ticks = high_run;
          reading.low_ticks  = low_run;
          reading.duty       = quotient[DUTY_W-1:0];
          reading.saturated  = (high_run == CNT_MAX) || (low_run == CNT_MAX);
          expected_readings.push_back(reading);
          capture_phase = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_reading();
    pwm_reading_t want;
    if (expected_readings.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: high %0d low %0d duty %0d sat %0b",
                 out_high_ticks, out_low_ticks, out_duty_percent_q8, out_saturated);
      end
    end else begin
      want = expected_readings.pop_front();
      if (want.high_ticks !== out_high_ticks || want.low_ticks !== out_low_ticks ||
          want.duty !== out_duty_percent_q8 || want.saturated !== out_saturated) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected high %0d low %0d duty %0d sat %0b",
                   want.high_ticks, want.low_ticks, want.duty, want.saturated);
          $display("                 actual   high %0d low %0d duty %0d sat %0b",
                   out_high_ticks, out_low_ticks, out_duty_percent_q8, out_saturated);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capture_phase = PH_IDLE;
      ticks_since_start = '0;
      interval_setting = IVL_RESET;
      high_run = '0;
      low_run = '0;
      expected_readings.delete();
    end else begin
      if (out_valid && !out_stall) begin
        check_reading();
      end
      if (in_valid && !in_stall) begin
        take_sample(in_pin_level);
      end
      if (cfg_valid && cfg_ready) begin
        interval_setting = cfg_interval_ticks;
      end
    end
    mismatch_count <= mismatches;
    readings_pending <= expected_readings.size();
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import pdcc_pkg::*;

  // The run is aborted when this many cycles go by without any transaction.
  // The slowest legitimate quiet stretch is the long output hold-off.
  localparam int WATCHDOG_LIMIT  = 4000;
  // Cycles left after the last reading before a register write or the verdict.
  localparam int SETTLE_CYCLES   = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int PHASE_ITEMS     = 330;

  // Hand-picked samples run with a zero interval, so every measurement starts
  // on the tick after the previous one ends. In order: an ignored low, one high and one low
  // tick (half duty), three high and one low, one high and four low, leading
  // low samples ignored while waiting for a high level followed by one high
  // and two low (a duty that must be floored), and finally a measurement left
  // open in its low phase.
  localparam int              DIRECTED_LEN  = 23;
  localparam logic [22:0]     DIRECTED_BITS = 23'b01011110110000100100110;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  logic   in_pin_level;
  logic   out_valid;
  logic   out_stall;
  count_t out_high_ticks;
  count_t out_low_ticks;
  duty_t  out_duty_percent_q8;
  logic   out_saturated;
  logic   cfg_valid;
  logic   cfg_ready;
  ivl_t   cfg_interval_ticks;

  int     mismatch_count;
  int     readings_pending;
  int     idle_cycles;

  // When set, neither the sample source nor the result sink inserts gaps.
  logic   quiet = 1'b0;
  // The main sequence bumps the request count; the sink process serves it.
  int     hold_offs_requested = 0;
  int     hold_offs_served = 0;

  pwm_duty_cycle_capture dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pin_level        (in_pin_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_high_ticks      (out_high_ticks),
    .out_low_ticks       (out_low_ticks),
    .out_duty_percent_q8 (out_duty_percent_q8),
    .out_saturated       (out_saturated),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_interval_ticks  (cfg_interval_ticks)
  );

  // The checker follows every transaction on the three channels, keeps its
  // own model of the capture logic and reports the running mismatch count and
  // the number of readings still owed by the block.
  pwm_capture_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pin_level        (in_pin_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_high_ticks      (out_high_ticks),
    .out_low_ticks       (out_low_ticks),
    .out_duty_percent_q8 (out_duty_percent_q8),
    .out_saturated       (out_saturated),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_interval_ticks  (cfg_interval_ticks),
    .mismatch_count      (mismatch_count),
    .readings_pending    (readings_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result sink. Normally it stalls in random bursts separated by free
  // stretches of random length. On request it holds off for a long stretch,
  // long enough that the block ends up stalling its sample input.
  initial begin
    int stall_len;
    int free_len;
    forever begin
      if (hold_offs_requested != hold_offs_served) begin
        hold_offs_served++;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        stall_len = $urandom_range(1, 11);
        free_len = $urandom_range(1, 20);
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
        out_stall <= 1'b0;
        repeat (free_len) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Watchdog: a hung handshake would otherwise stall the run forever.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one pin sample and returns at the edge where it is taken. Before
  // the sample the source may go quiet for a random burst of cycles.
  task automatic send_sample(input logic level);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pin_level <= level;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly a PWM waveform with random high and low run lengths, so that the
  // block walks through complete measurements; now and then a short run of
  // random samples breaks the pattern. Run lengths are usually short, with an
  // occasional long one to exercise wider counts.
  task automatic send_mix(input int n_items);
    int sent;
    int high_len;
    int low_len;
    int noise_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        low_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        repeat (high_len) send_sample(1'b1);
        repeat (low_len) send_sample(1'b0);
        sent += high_len + low_len;
      end else begin
        noise_len = $urandom_range(1, 8);
        repeat (noise_len) send_sample(1'($urandom_range(0, 1)));
        sent += noise_len;
      end
    end
  endtask

  // Stops the samples, waits for every owed reading and lets the divider
  // settle, so no reading or divide is still in flight afterwards.
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(posedge clk); while (readings_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input ivl_t ticks);
    cfg_valid <= 1'b1;
    cfg_interval_ticks <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_pin_level <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_interval_ticks <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // With the reset interval of 10000 ticks, a few samples must produce
    // nothing at all.
    repeat (12) send_sample(1'($urandom_range(0, 1)));
    finish_phase();

    // A zero interval behaves like one tick; run the hand-picked samples.
    write_interval('0);
    for (int i = DIRECTED_LEN - 1; i >= 0; i--) begin
      send_sample(DIRECTED_BITS[i]);
    end
    finish_phase();

    // The largest interval: at most the measurement left open above can
    // complete, after which no new one starts.
    write_interval(IVL_MAX);
    repeat (20) send_sample(1'($urandom_range(0, 1)));
    finish_phase();

    // Shortest legal interval, with one long hold-off on the result side while
    // samples keep coming, so the block fills up and stalls its input.
    write_interval(ivl_t'(1));
    hold_offs_requested++;
    send_mix(PHASE_ITEMS);
    finish_phase();

    // A random short interval. Halfway through, the source pauses until every
    // reading has come back before it continues.
    write_interval(ivl_t'($urandom_range(2, 40)));
    send_mix(PHASE_ITEMS / 2);
    finish_phase();
    send_mix(PHASE_ITEMS / 2);
    finish_phase();

    // A longer interval: many samples fall into the idle wait.
    write_interval(ivl_t'(150));
    send_mix(PHASE_ITEMS);
    finish_phase();

    // Final stretch at full rate on both sides.
    quiet = 1'b1;
    write_interval(ivl_t'($urandom_range(1, 8)));
    send_mix(PHASE_ITEMS);
    finish_phase();

    if (mismatch_count == 0 && readings_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[pwm_duty_cycle_capture.f]
+incdir+hw/rtl
hw/rtl/pdcc_pkg.sv
hw/rtl/pdcc_div.sv
hw/rtl/pwm_duty_cycle_capture.sv
hw/rtl/pdcc_chk.sv
sim/pwm_capture_checker.sv
sim/tb_top.sv
